FILE: rtl/core/fir_filter_top_assert.svh
// Assertion macros for the checker file of the FIR filter.
`ifndef FIR_FILTER_TOP_ASSERT_SVH
`define FIR_FILTER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FIR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FIR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/fir_pkg.sv
`default_nettype none

package fir_pkg;

    localparam int MAX_TAPS_DEF    = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int CMD_W     = 2;
    localparam int TAP_IDX_W = 6;
    localparam int TAPS_W    = 7;

    localparam logic [TAPS_W-1:0] TAPS_RESET = 7'd51;

    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FILTER = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    typedef struct packed {
        logic coef_we;
        logic hist_we;
        logic hist_clr;
        logic rd_en;
    } store_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/fir_store.sv
`default_nettype none

module fir_store #(
    parameter int MAX_TAPS    = fir_pkg::MAX_TAPS_DEF,
    parameter int SAMPLE_BITS = fir_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire fir_pkg::store_ctrl_t          ctrl,
    input  wire logic [$clog2(MAX_TAPS)-1:0]   coef_waddr,
    input  wire logic [$clog2(MAX_TAPS)-1:0]   hist_waddr,
    input  wire logic [SAMPLE_BITS-1:0]        wdata,
    input  wire logic [$clog2(MAX_TAPS)-1:0]   coef_raddr,
    input  wire logic [$clog2(MAX_TAPS)-1:0]   hist_raddr,
    output logic signed [SAMPLE_BITS-1:0]      coef_q,
    output logic signed [SAMPLE_BITS-1:0]      samp_q,
    output logic                               rd_vld
);

    logic [SAMPLE_BITS-1:0] coef_mem_reg [MAX_TAPS];
    logic [SAMPLE_BITS-1:0] hist_mem_reg [MAX_TAPS];
    logic [MAX_TAPS-1:0]    coef_vld_reg;
    logic [MAX_TAPS-1:0]    hist_vld_reg;
    logic [SAMPLE_BITS-1:0] coef_rd_reg;
    logic [SAMPLE_BITS-1:0] hist_rd_reg;
    logic                   coef_rv_reg;
    logic                   hist_rv_reg;
    logic                   rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.coef_we) begin
            coef_mem_reg[coef_waddr] <= wdata;
        end
        if (ctrl.hist_we) begin
            hist_mem_reg[hist_waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.rd_en) begin
            coef_rd_reg <= coef_mem_reg[coef_raddr];
            hist_rd_reg <= hist_mem_reg[hist_raddr];
            coef_rv_reg <= coef_vld_reg[coef_raddr];
            hist_rv_reg <= hist_vld_reg[hist_raddr];
        end
    end

    // An entry never written since reset, or a history entry not written since a clear, reads as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_vld_reg <= '0;
        end else if (ctrl.coef_we) begin
            coef_vld_reg[coef_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.hist_clr) begin
            hist_vld_reg <= '0;
        end else if (ctrl.hist_we) begin
            hist_vld_reg[hist_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= ctrl.rd_en;
        end
    end

    assign coef_q = coef_rv_reg ? coef_rd_reg : '0;
    assign samp_q = hist_rv_reg ? hist_rd_reg : '0;
    assign rd_vld = rd_vld_reg;

endmodule

`default_nettype wire

FILE: rtl/core/fir_mac.sv
`default_nettype none

module fir_mac #(
    parameter int MAX_TAPS    = fir_pkg::MAX_TAPS_DEF,
    parameter int SAMPLE_BITS = fir_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          acc_clear,
    input  wire logic                          in_vld,
    input  wire logic signed [SAMPLE_BITS-1:0] coef,
    input  wire logic signed [SAMPLE_BITS-1:0] samp,
    output logic                               busy,
    output logic [SAMPLE_BITS-1:0]             result,
    output logic                               saturated
);

    localparam int IDX_W  = $clog2(MAX_TAPS);
    localparam int PROD_W = 2 * SAMPLE_BITS;
    localparam int FULL_W = PROD_W + IDX_W + 1;
    localparam int ACC_W  = (FULL_W > 64) ? 64 : FULL_W;
    localparam int FRAC   = SAMPLE_BITS - 1;

    localparam logic signed [ACC_W:0] HALF =
        {{(ACC_W + 1 - FRAC){1'b0}}, 1'b1, {(FRAC - 1){1'b0}}};
    localparam logic signed [ACC_W:0] SMAX =
        {{(ACC_W + 2 - SAMPLE_BITS){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [ACC_W:0] SMIN =
        {{(ACC_W + 2 - SAMPLE_BITS){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic        [ACC_W:0]    sum;
    logic signed [ACC_W:0]    rnd;
    logic signed [ACC_W:0]    shifted;

    always_ff @(posedge aclk) begin
        prod_reg <= coef * samp;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= in_vld;
        end
    end

    // The running sum clips at the accumulator range instead of wrapping.
    always_comb begin
        sum = {acc_reg[ACC_W-1], acc_reg}
            + {{(ACC_W + 1 - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        if (sum[ACC_W] != sum[ACC_W-1]) begin
            acc_next = sum[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}}
                                  : {1'b0, {(ACC_W - 1){1'b1}}};
        end else begin
            acc_next = sum[ACC_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (acc_clear) begin
            acc_reg <= '0;
        end else if (prod_vld_reg) begin
            acc_reg <= acc_next;
        end
    end

    always_comb begin
        rnd     = {acc_reg[ACC_W-1], acc_reg} + HALF;
        shifted = rnd >>> FRAC;
        if (shifted > SMAX) begin
            result    = SMAX[SAMPLE_BITS-1:0];
            saturated = 1'b1;
        end else if (shifted < SMIN) begin
            result    = SMIN[SAMPLE_BITS-1:0];
            saturated = 1'b1;
        end else begin
            result    = shifted[SAMPLE_BITS-1:0];
            saturated = 1'b0;
        end
    end

    assign busy = in_vld | prod_vld_reg;

endmodule

`default_nettype wire

FILE: rtl/core/fir_filter_top.sv
`default_nettype none

// Direct-form FIR filter with one shared multiply-accumulate unit. Each input word
// carries a command in s_tuser: load a coefficient at tap_index, filter a sample,
// or clear the sample history. Only a sample word returns an output word, the
// rounded and saturated Q1.15 sum of taps_in_use products, with s_tuser-style
// flag m_tuser set when the output was clipped. Load and clear words are taken
// straight from the idle state. A sample word holds the input while the sample is
// stored, each of the effective taps (51 at reset) passes through the single
// multiplier in turn, the read and multiply stages drain, and the sum is rounded
// into the output register, which then frees the input while the result waits to
// be taken. If the previous result is still waiting, the round step also waits
// until that result is taken. The tap count is written on the cfg port; 0 behaves
// as 1 and values above MAX_TAPS as MAX_TAPS.
// Write it only while idle.
module fir_filter_top #(
    parameter int MAX_TAPS    = fir_pkg::MAX_TAPS_DEF,
    parameter int SAMPLE_BITS = fir_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                              aclk,
    input  wire logic                                              aresetn,
    input  wire logic                                              s_tvalid,
    output logic                                                   s_tready,
    // tap_index, value
    input  wire logic [((fir_pkg::TAP_IDX_W+SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    // cmd
    input  wire logic [fir_pkg::CMD_W-1:0]                         s_tuser,
    output logic                                                   m_tvalid,
    input  wire logic                                              m_tready,
    // filtered_sample
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]                       m_tdata,
    // saturated
    output logic [0:0]                                             m_tuser,
    input  wire logic                                              cfg_valid,
    output logic                                                   cfg_ready,
    input  wire logic [fir_pkg::TAPS_W-1:0]                        cfg_data
);

    localparam int IDX_W     = $clog2(MAX_TAPS);
    localparam int M_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_ROUND = 4'b1000
    } state_t;

    state_t                        state_reg, state_next;
    logic [IDX_W-1:0]              k_reg, k_next;
    logic [IDX_W-1:0]              rd_reg, rd_next;
    logic [IDX_W-1:0]              last_reg, last_next;
    logic [IDX_W-1:0]              newest_reg, newest_next;
    logic [fir_pkg::TAPS_W-1:0]    taps_reg;
    logic                          out_vld_reg, out_vld_next;
    logic [SAMPLE_BITS-1:0]        out_data_reg, out_data_next;
    logic                          out_sat_reg, out_sat_next;

    fir_pkg::store_ctrl_t          store_ctrl;
    logic                          acc_clear;
    logic                          s_accept;
    logic [fir_pkg::TAP_IDX_W-1:0] s_tap;
    logic [SAMPLE_BITS-1:0]        s_value;
    logic                          tap_ok;
    logic [IDX_W-1:0]              pos;
    logic [IDX_W-1:0]              rd_dec;
    logic [IDX_W-1:0]              last_eff;
    logic signed [SAMPLE_BITS-1:0] coef_q;
    logic signed [SAMPLE_BITS-1:0] samp_q;
    logic                          rd_vld;
    logic                          mac_busy;
    logic [SAMPLE_BITS-1:0]        mac_result;
    logic                          mac_sat;

    assign s_tap    = s_tdata[fir_pkg::TAP_IDX_W-1:0];
    assign s_value  = s_tdata[fir_pkg::TAP_IDX_W +: SAMPLE_BITS];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid & s_tready;
    assign tap_ok   = (32'(s_tap) < MAX_TAPS);

    assign pos    = (newest_reg == IDX_W'(MAX_TAPS - 1)) ? '0 : newest_reg + 1'b1;
    assign rd_dec = (rd_reg == '0) ? IDX_W'(MAX_TAPS - 1) : rd_reg - 1'b1;

    always_comb begin
        if (taps_reg == '0) begin
            last_eff = '0;
        end else if (32'(taps_reg) > MAX_TAPS) begin
            last_eff = IDX_W'(MAX_TAPS - 1);
        end else begin
            last_eff = IDX_W'(32'(taps_reg) - 1);
        end
    end

    always_comb begin
        state_next    = state_reg;
        k_next        = k_reg;
        rd_next       = rd_reg;
        last_next     = last_reg;
        newest_next   = newest_reg;
        out_vld_next  = out_vld_reg;
        out_data_next = out_data_reg;
        out_sat_next  = out_sat_reg;
        store_ctrl    = '0;
        acc_clear     = 1'b0;

        if (out_vld_reg && m_tready) begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    case (s_tuser)
                        fir_pkg::CMD_LOAD: begin
                            store_ctrl.coef_we = tap_ok;
                        end
                        fir_pkg::CMD_CLEAR: begin
                            store_ctrl.hist_clr = 1'b1;
                            newest_next         = '0;
                        end
                        fir_pkg::CMD_FILTER: begin
                            store_ctrl.hist_we = 1'b1;
                            newest_next        = pos;
                            rd_next            = pos;
                            k_next             = '0;
                            last_next          = last_eff;
                            acc_clear          = 1'b1;
                            state_next         = ST_RUN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RUN: begin
                store_ctrl.rd_en = 1'b1;
                k_next           = k_reg + 1'b1;
                rd_next          = rd_dec;
                if (k_reg == last_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!mac_busy) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (!out_vld_reg || m_tready) begin
                    out_vld_next  = 1'b1;
                    out_data_next = mac_result;
                    out_sat_next  = mac_sat;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            out_vld_reg <= 1'b0;
            newest_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
            newest_reg  <= newest_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg        <= k_next;
        rd_reg       <= rd_next;
        last_reg     <= last_next;
        out_data_reg <= out_data_next;
        out_sat_reg  <= out_sat_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            taps_reg <= fir_pkg::TAPS_RESET;
        end else if (cfg_valid) begin
            taps_reg <= cfg_data;
        end
    end

    fir_store #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (store_ctrl),
        .coef_waddr (IDX_W'(s_tap)),
        .hist_waddr (pos),
        .wdata      (s_value),
        .coef_raddr (k_reg),
        .hist_raddr (rd_reg),
        .coef_q     (coef_q),
        .samp_q     (samp_q),
        .rd_vld     (rd_vld)
    );

    fir_mac #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .acc_clear (acc_clear),
        .in_vld    (rd_vld),
        .coef      (coef_q),
        .samp      (samp_q),
        .busy      (mac_busy),
        .result    (mac_result),
        .saturated (mac_sat)
    );

    assign cfg_ready  = 1'b1;
    assign m_tvalid   = out_vld_reg;
    assign m_tdata    = M_TDATA_W'(out_data_reg);
    assign m_tuser[0] = out_sat_reg;

endmodule

`default_nettype wire

FILE: rtl/core/fir_checker.sv
`default_nettype none

`include "fir_filter_top_assert.svh"

module fir_checker #(
    parameter int SAMPLE_BITS = fir_pkg::SAMPLE_BITS_DEF
) (
    input wire logic                                                aclk,
    input wire logic                                                aresetn,
    input wire logic                                                s_tvalid,
    input wire logic                                                s_tready,
    input wire logic [fir_pkg::CMD_W-1:0]                           s_tuser,
    input wire logic                                                m_tvalid,
    input wire logic                                                m_tready,
    input wire logic [((SAMPLE_BITS+7)/8)*8-1:0]                    m_tdata,
    input wire logic [0:0]                                          m_tuser
);

    localparam logic [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    `FIR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output word changed while stalled")

    `FIR_ASSERT_NEXT(a_busy_after_sample, s_tvalid && s_tready && s_tuser == fir_pkg::CMD_FILTER,
        !s_tready, "input still ready after a sample word")

    `FIR_ASSERT_NOW(a_sat_value, m_tvalid && m_tuser[0],
        m_tdata[SAMPLE_BITS-1:0] == SMAX || m_tdata[SAMPLE_BITS-1:0] == SMIN,
        "saturation flag on an unclipped output")

    `FIR_ASSERT_NOW(a_result_source, $rose(m_tvalid), $past(!s_tready),
        "output word appeared without a sample in progress")

    `FIR_ASSERT_NEXT(a_no_spurious, s_tvalid && s_tready && s_tuser != fir_pkg::CMD_FILTER &&
        !m_tvalid, !m_tvalid, "output word after a load or clear word")

endmodule

bind fir_filter_top fir_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_fir_checker (.*);

`default_nettype wire

FILE: bench/fir_filter_scoreboard.sv
`timescale 1ns / 100ps

module fir_filter_scoreboard
    import fir_pkg::*;
#(
    parameter int S_DATA_W = ((TAP_IDX_W + SAMPLE_BITS_DEF + 7) / 8) * 8,
    parameter int M_DATA_W = ((SAMPLE_BITS_DEF + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [CMD_W-1:0]    s_tuser,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,
    input  logic [0:0]          m_tuser,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [TAPS_W-1:0]   cfg_data,
    output int                  mismatches,
    output int                  outstanding
);

    localparam longint OUT_MAX = (64'sd1 <<< (SAMPLE_BITS_DEF - 1)) - 1;
    localparam longint OUT_MIN = -(64'sd1 <<< (SAMPLE_BITS_DEF - 1));

    typedef struct packed {
        logic signed [SAMPLE_BITS_DEF-1:0] sample;
        logic                              clipped;
    } fir_output_t;

    logic signed [SAMPLE_BITS_DEF-1:0] coef_mem [MAX_TAPS_DEF];
    logic signed [SAMPLE_BITS_DEF-1:0] history [MAX_TAPS_DEF];
    logic [TAP_IDX_W-1:0]              newest;
    logic [TAPS_W-1:0]                 tap_count;
    fir_output_t                       awaited_outputs[$];
    int                                error_total = 0;

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    // Pushes the sample into the history ring and returns the rounded,
    // saturated dot product over the taps in use.
    function automatic fir_output_t filter_sample(input logic signed [SAMPLE_BITS_DEF-1:0] x);
        fir_output_t          result;
        logic [TAP_IDX_W-1:0] slot;
        int                   n_taps;
        longint               acc;
        longint               y;
        newest = newest + 1'b1;
        history[newest] = x;
        if (tap_count == 0) begin
            n_taps = 1;
        end else if (tap_count > MAX_TAPS_DEF) begin
            n_taps = MAX_TAPS_DEF;
        end else begin
            n_taps = tap_count;
        end
        acc = 0;
        for (int k = 0; k < n_taps; k++) begin
            slot = newest - TAP_IDX_W'(k);
            acc += longint'(coef_mem[k]) * longint'(history[slot]);
        end
        y = (acc + (64'sd1 <<< (SAMPLE_BITS_DEF - 2))) >>> (SAMPLE_BITS_DEF - 1);
        result.clipped = 1'b0;
        if (y > OUT_MAX) begin
            y = OUT_MAX;
            result.clipped = 1'b1;
        end else if (y < OUT_MIN) begin
            y = OUT_MIN;
            result.clipped = 1'b1;
        end
        result.sample = y[SAMPLE_BITS_DEF-1:0];
        return result;
    endfunction

    always @(posedge aclk) begin
        fir_output_t                       want;
        logic signed [SAMPLE_BITS_DEF-1:0] got_sample;
        logic signed [SAMPLE_BITS_DEF-1:0] word_value;
        got_sample = m_tdata[SAMPLE_BITS_DEF-1:0];
        word_value = s_tdata[TAP_IDX_W +: SAMPLE_BITS_DEF];
        if (!aresetn) begin
            for (int i = 0; i < MAX_TAPS_DEF; i++) begin
                coef_mem[i] = '0;
                history[i]  = '0;
            end
            newest    = '0;
            tap_count = TAPS_RESET;
            awaited_outputs.delete();
        end else begin
            // The result of a sample accepted at this edge cannot leave yet,
            // so the output side is checked first.
            if (m_tvalid && m_tready) begin
                if (awaited_outputs.size() == 0) begin
                    error_total++;
                    $display("%0t: output word with none expected: sample %0d, saturated %0b",
                             $time, got_sample, m_tuser[0]);
                end else begin
                    want = awaited_outputs.pop_front();
                    if (got_sample !== want.sample) begin
                        error_total++;
                        $display("%0t: filtered_sample expected %0d, actual %0d",
                                 $time, want.sample, got_sample);
                    end
                    if (m_tuser[0] !== want.clipped) begin
                        error_total++;
                        $display("%0t: saturated expected %0b, actual %0b",
                                 $time, want.clipped, m_tuser[0]);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    CMD_LOAD: begin
                        coef_mem[s_tdata[TAP_IDX_W-1:0]] = word_value;
                    end
                    CMD_FILTER: begin
                        awaited_outputs.push_back(filter_sample(word_value));
                    end
                    CMD_CLEAR: begin
                        for (int i = 0; i < MAX_TAPS_DEF; i++) begin
                            history[i] = '0;
                        end
                        newest = '0;
                    end
                    default: begin
                    end
                endcase
            end
            if (cfg_valid && cfg_ready) begin
                tap_count = cfg_data;
            end
        end
        mismatches  <= error_total;
        outstanding <= awaited_outputs.size();
    end

endmodule

FILE: bench/fir_filter_top_test.sv
`timescale 1ns / 100ps

module fir_filter_top_test;
    import fir_pkg::*;

    localparam int S_DATA_W = ((TAP_IDX_W + SAMPLE_BITS_DEF + 7) / 8) * 8;
    localparam int M_DATA_W = ((SAMPLE_BITS_DEF + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

    localparam int SETTLE_CYCLES   = 80;
    localparam int STALL_LIMIT     = 2000;
    localparam int ITEMS_PER_PHASE = 105;
    localparam int PHASES          = 9;

    localparam logic signed [15:0] Q15_MAX = 16'sh7FFF;
    localparam logic signed [15:0] Q15_MIN = -16'sh8000;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [CMD_W-1:0]    s_tuser;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [0:0]          m_tuser;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [TAPS_W-1:0]   cfg_data;

    int   mismatches;
    int   outstanding;
    int   quiet_cycles = 0;
    int   ready_hold = 0;
    logic sender_bursts;
    logic receiver_stalls;

    always #1 aclk = ~aclk;

    fir_filter_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    fir_filter_scoreboard scoreboard (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 9);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [15:0] random_q15();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            case ($urandom_range(0, 4))
                0: return Q15_MAX;
                1: return Q15_MIN;
                2: return 16'sd0;
                3: return 16'sd1;
                default: return -16'sd1;
            endcase
        end else if (r < 55) begin
            return 16'($signed($urandom_range(0, 2047)) - 1024);
        end
        return 16'($urandom);
    endfunction

    // The receiver stalls at random in some phases and never in others.
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_tready   <= 1'b0;
        end else if (!receiver_stalls || $urandom_range(0, 3) != 0) begin
            m_tready <= 1'b1;
        end else begin
            m_tready   <= 1'b0;
            ready_hold <= idle_length() - 1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("fir_filter_top: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [TAP_IDX_W-1:0] tap,
                             input logic signed [15:0] value);
        int gap;
        gap = 0;
        if (!sender_bursts && $urandom_range(0, 99) >= 55) begin
            gap = idle_length();
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= S_DATA_W'({value, tap});
        do @(posedge aclk); while (!s_tready);
    endtask

    // Loads and clears return nothing, so the block gets time to finish any
    // work still in flight before the tap count changes.
    task automatic write_taps(input logic [TAPS_W-1:0] taps);
        s_tvalid <= 1'b0;
        repeat (SETTLE_CYCLES) @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= taps;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int active_taps);
        int taken;
        int r;
        logic [TAP_IDX_W-1:0] tap;
        taken = 0;
        if ($urandom_range(0, 1) == 1) begin
            send_word(CMD_CLEAR, TAP_IDX_W'($urandom), random_q15());
            taken++;
        end
        for (int i = 0; i < 12; i++) begin
            send_word(CMD_LOAD, TAP_IDX_W'($urandom_range(0, active_taps - 1)), random_q15());
            taken++;
        end
        while (taken < ITEMS_PER_PHASE) begin
            r = $urandom_range(0, 99);
            if (r < 62) begin
                send_word(CMD_FILTER, TAP_IDX_W'($urandom), random_q15());
                taken++;
            end else if (r < 86) begin
                if (r < 80) begin
                    tap = TAP_IDX_W'($urandom_range(0, active_taps - 1));
                end else begin
                    tap = TAP_IDX_W'($urandom);
                end
                send_word(CMD_LOAD, tap, random_q15());
                taken++;
            end else if (r < 92) begin
                send_word(CMD_CLEAR, TAP_IDX_W'($urandom), random_q15());
                taken++;
            end else begin
                send_word(CMD_NONE, TAP_IDX_W'($urandom), random_q15());
                taken++;
            end
        end
    endtask

    initial begin
        logic [TAPS_W-1:0] phase_taps [PHASES];
        int                active;
        phase_taps = '{7'd0, 7'd1, 7'd2, 7'd64, 7'd65, 7'd127,
                       TAPS_W'($urandom_range(3, 50)), TAPS_W'($urandom_range(52, 63)), 7'd51};
        aresetn         <= 1'b0;
        s_tvalid        <= 1'b0;
        s_tdata         <= '0;
        s_tuser         <= CMD_LOAD;
        cfg_valid       <= 1'b0;
        cfg_data        <= '0;
        sender_bursts   <= 1'b0;
        receiver_stalls <= 1'b1;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        send_word(CMD_FILTER, 6'd0, Q15_MAX);
        send_word(CMD_LOAD, 6'd0, Q15_MAX);
        send_word(CMD_LOAD, 6'd63, Q15_MIN);
        send_word(CMD_FILTER, 6'd63, Q15_MAX);
        send_word(CMD_FILTER, 6'd0, Q15_MIN);
        send_word(CMD_LOAD, 6'd0, Q15_MIN);
        send_word(CMD_FILTER, 6'd0, Q15_MIN);
        send_word(CMD_LOAD, 6'd1, Q15_MIN);
        send_word(CMD_FILTER, 6'd0, Q15_MAX);
        send_word(CMD_FILTER, 6'd0, Q15_MAX);
        send_word(CMD_NONE, 6'd63, Q15_MIN);
        send_word(CMD_CLEAR, 6'd63, Q15_MAX);
        send_word(CMD_FILTER, 6'd0, 16'sd1);
        send_word(CMD_FILTER, 6'd0, -16'sd1);
        send_word(CMD_LOAD, 6'd50, Q15_MAX);
        send_word(CMD_LOAD, 6'd51, Q15_MAX);
        send_word(CMD_LOAD, 6'd1, 16'sd0);
        send_word(CMD_FILTER, 6'd0, 16'sd16384);
        send_word(CMD_FILTER, 6'd0, 16'sd0);
        send_word(CMD_CLEAR, 6'd0, 16'sd0);
        send_word(CMD_FILTER, 6'd21, -16'sd21846);

        for (int p = 0; p < PHASES; p++) begin
            write_taps(phase_taps[p]);
            sender_bursts   <= (p % 3 == 1);
            receiver_stalls <= (p % 4 != 2);
            if (phase_taps[p] == 0) begin
                active = 1;
            end else if (phase_taps[p] > MAX_TAPS_DEF) begin
                active = MAX_TAPS_DEF;
            end else begin
                active = phase_taps[p];
            end
            run_phase(active);
        end

        s_tvalid <= 1'b0;
        repeat (SETTLE_CYCLES) @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("fir_filter_top: match");
        end else begin
            $display("fir_filter_top: mismatch");
        end
        $finish;
    end

endmodule
